// ===== design/tctp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tctp_pkg;

    // Table geometry of the command targets.
    localparam int unsigned COLUMNS     = 3;
    localparam int unsigned HEATER_ROWS = 6;
    localparam int unsigned SCAN_ROWS   = 27;

    // Characters the parser recognizes.
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_U     = 8'h75;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_D     = 8'h64;
    localparam logic [7:0] CHAR_H     = 8'h68;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_C     = 8'h63;

    // Value reported for a column whose character is missing.
    localparam logic [7:0] MISSING_DIGIT = 8'd208;

    // Result kinds.
    localparam logic [2:0] KIND_MODE       = 3'd0;
    localparam logic [2:0] KIND_HEATER     = 3'd1;
    localparam logic [2:0] KIND_SCAN       = 3'd2;
    localparam logic [2:0] KIND_SAMPLING   = 3'd3;
    localparam logic [2:0] KIND_FRAME_DONE = 3'd4;
    localparam logic [2:0] KIND_BAD_HEADER = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN    = 3'd6;
    localparam logic [2:0] KIND_ROW_RANGE  = 3'd7;

    // Section codes.
    localparam logic [1:0] SEC_MODE     = 2'd0;
    localparam logic [1:0] SEC_HEATER   = 2'd1;
    localparam logic [1:0] SEC_SCAN     = 2'd2;
    localparam logic [1:0] SEC_SAMPLING = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] row_index;
        logic [7:0] value_first;
        logic [7:0] value_second;
        logic [7:0] value_third;
        logic       last_result;
    } out_item_t;

endpackage

`default_nettype wire

// ===== design/telecommand_token_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Telecommand token parser. Each accepted request is one byte of a comma-separated
// command frame ("tub,<n>,<tag>,<count>,<params>..."); the parse state is updated in
// the cycle the byte is accepted and the results it causes are written into a
// four-entry result queue in that same cycle. A new byte can be accepted every cycle
// while the queue holds two or fewer results; only a byte that ends a frame can
// produce two results (a write or error, then frame done), so the single result port,
// draining one result per cycle while m_ready is high, sets the sustained rate.
// Results leave the registered queue on m_payload, oldest first.
module telecommand_token_parser_core (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire tctp_pkg::in_item_t s_payload,
    output logic                 m_valid,
    input  wire                  m_ready,
    output tctp_pkg::out_item_t  m_payload
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COUNT,
        PH_TAG,
        PH_PCOUNT,
        PH_PARAM,
        PH_TRAIL
    } phase_t;

    localparam int unsigned QDEPTH = 4;

    // Parse state.
    phase_t     phase_reg, phase_next;
    logic [7:0] tok_chars_reg [3];
    logic [1:0] tok_len_reg;
    logic [3:0] sections_left_reg, sections_left_next;
    logic [3:0] params_left_reg, params_left_next;
    logic [1:0] section_reg, section_next;
    logic [4:0] next_row_reg, next_row_next;
    logic       frame_dead_reg, frame_dead_next;

    // Result queue.
    tctp_pkg::out_item_t q_reg [QDEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    // Working signals for the accepted byte.
    logic       s_fire;
    logic       m_fire;
    logic       is_comma;
    logic       token_done;
    logic [7:0] tc [3];
    logic [1:0] tl;
    logic [7:0] digit [3];
    logic [7:0] col [3];
    logic       tok_res_valid;
    tctp_pkg::out_item_t tok_res;
    tctp_pkg::out_item_t done_res;
    tctp_pkg::out_item_t push0;
    tctp_pkg::out_item_t push1;
    logic [1:0] push_cnt;

    function automatic logic [3:0] sat15(input logic [7:0] v);
        return (v > 8'd15) ? 4'd15 : v[3:0];
    endfunction

    function automatic tctp_pkg::out_item_t mk_res(
        input logic [2:0] kind,
        input logic [4:0] row,
        input logic [7:0] v1,
        input logic [7:0] v2,
        input logic [7:0] v3
    );
        tctp_pkg::out_item_t r;
        r.kind         = kind;
        r.row_index    = row;
        r.value_first  = v1;
        r.value_second = v2;
        r.value_third  = v3;
        r.last_result  = 1'b0;
        return r;
    endfunction

    assign s_ready   = (count_reg <= 3'd2);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = (count_reg != 3'd0);
    assign m_fire    = m_valid && m_ready;
    assign m_payload = q_reg[rd_ptr_reg];

    assign is_comma   = (s_payload.in_byte == tctp_pkg::CHAR_COMMA);
    assign token_done = is_comma || s_payload.frame_end;

    // Token as it stands once the incoming byte is appended.
    always_comb begin
        tc[0] = tok_chars_reg[0];
        tc[1] = tok_chars_reg[1];
        tc[2] = tok_chars_reg[2];
        tl    = tok_len_reg;
        if (!is_comma && tok_len_reg != 2'd3) begin
            unique case (tok_len_reg)
                2'd0:    tc[0] = s_payload.in_byte;
                2'd1:    tc[1] = s_payload.in_byte;
                default: tc[2] = s_payload.in_byte;
            endcase
            tl = tok_len_reg + 2'd1;
        end
    end

    // Digit and column values of the token; missing characters read as 208.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            digit[i] = (tl > 2'(i)) ? (tc[i] - tctp_pkg::CHAR_ZERO)
                                    : tctp_pkg::MISSING_DIGIT;
            col[i]   = (i < tctp_pkg::COLUMNS) ? digit[i] : 8'd0;
        end
    end

    // Token completion: phase transitions and the result it may produce.
    always_comb begin
        phase_next         = phase_reg;
        sections_left_next = sections_left_reg;
        params_left_next   = params_left_reg;
        section_next       = section_reg;
        next_row_next      = next_row_reg;
        frame_dead_next    = frame_dead_reg;
        tok_res_valid      = 1'b0;
        tok_res            = mk_res(tctp_pkg::KIND_MODE, 5'd0, 8'd0, 8'd0, 8'd0);

        if (token_done && !frame_dead_reg) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (tl == 2'd3 && tc[0] == tctp_pkg::CHAR_T
                        && tc[1] == tctp_pkg::CHAR_U && tc[2] == tctp_pkg::CHAR_B) begin
                        phase_next = PH_COUNT;
                    end else begin
                        tok_res_valid   = 1'b1;
                        tok_res         = mk_res(tctp_pkg::KIND_BAD_HEADER, 5'd0,
                                                 8'd0, 8'd0, 8'd0);
                        frame_dead_next = 1'b1;
                    end
                end
                PH_COUNT: begin
                    sections_left_next = sat15(digit[0]);
                    phase_next = (sat15(digit[0]) != 4'd0) ? PH_TAG : PH_TRAIL;
                end
                PH_TAG: begin
                    priority if (tl >= 2'd2 && tc[0] == tctp_pkg::CHAR_M
                                 && tc[1] == tctp_pkg::CHAR_D) begin
                        section_next = tctp_pkg::SEC_MODE;
                        phase_next   = PH_PCOUNT;
                    end else if (tl >= 2'd2 && tc[0] == tctp_pkg::CHAR_H
                                 && tc[1] == tctp_pkg::CHAR_T) begin
                        section_next = tctp_pkg::SEC_HEATER;
                        phase_next   = PH_PCOUNT;
                    end else if (tl >= 2'd2 && tc[0] == tctp_pkg::CHAR_S
                                 && tc[1] == tctp_pkg::CHAR_C) begin
                        section_next = tctp_pkg::SEC_SCAN;
                        phase_next   = PH_PCOUNT;
                    end else if (tl >= 2'd2 && tc[0] == tctp_pkg::CHAR_S
                                 && tc[1] == tctp_pkg::CHAR_S) begin
                        section_next = tctp_pkg::SEC_SAMPLING;
                        phase_next   = PH_PCOUNT;
                    end else begin
                        tok_res_valid   = 1'b1;
                        tok_res         = mk_res(tctp_pkg::KIND_UNKNOWN, 5'd0,
                                                 8'd0, 8'd0, 8'd0);
                        frame_dead_next = 1'b1;
                    end
                end
                PH_PCOUNT: begin
                    params_left_next = sat15(digit[0]);
                    next_row_next    = 5'd0;
                    if (sat15(digit[0]) == 4'd0) begin
                        // Empty section closes at once.
                        if (sections_left_reg != 4'd0) begin
                            sections_left_next = sections_left_reg - 4'd1;
                        end
                        phase_next = (sections_left_reg > 4'd1) ? PH_TAG : PH_TRAIL;
                    end else begin
                        phase_next = PH_PARAM;
                    end
                end
                PH_PARAM: begin
                    unique case (section_reg)
                        tctp_pkg::SEC_MODE: begin
                            tok_res_valid = (next_row_reg == 5'd0);
                            tok_res = mk_res(tctp_pkg::KIND_MODE, 5'd0, digit[0],
                                             8'd0, 8'd0);
                        end
                        tctp_pkg::SEC_SAMPLING: begin
                            tok_res_valid = (next_row_reg == 5'd0);
                            tok_res = mk_res(tctp_pkg::KIND_SAMPLING, 5'd0,
                                             (tl != 2'd0) ? tc[0] : 8'd0, 8'd0, 8'd0);
                        end
                        tctp_pkg::SEC_HEATER: begin
                            tok_res_valid = 1'b1;
                            if (32'(next_row_reg) >= tctp_pkg::HEATER_ROWS) begin
                                tok_res = mk_res(tctp_pkg::KIND_ROW_RANGE, next_row_reg,
                                                 8'd0, 8'd0, 8'd0);
                            end else begin
                                tok_res = mk_res(tctp_pkg::KIND_HEATER, next_row_reg,
                                                 col[0], col[1], col[2]);
                            end
                        end
                        default: begin
                            tok_res_valid = 1'b1;
                            if (32'(next_row_reg) >= tctp_pkg::SCAN_ROWS) begin
                                tok_res = mk_res(tctp_pkg::KIND_ROW_RANGE, next_row_reg,
                                                 8'd0, 8'd0, 8'd0);
                            end else begin
                                tok_res = mk_res(tctp_pkg::KIND_SCAN, next_row_reg,
                                                 col[0], col[1], col[2]);
                            end
                        end
                    endcase
                    if (next_row_reg != 5'd31) begin
                        next_row_next = next_row_reg + 5'd1;
                    end
                    if (params_left_reg != 4'd0) begin
                        params_left_next = params_left_reg - 4'd1;
                    end
                    // Last parameter closes the section.
                    if (params_left_reg <= 4'd1) begin
                        if (sections_left_reg != 4'd0) begin
                            sections_left_next = sections_left_reg - 4'd1;
                        end
                        phase_next = (sections_left_reg > 4'd1) ? PH_TAG : PH_TRAIL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Results pushed into the queue for this byte, with the last one marked.
    always_comb begin
        done_res = mk_res(tctp_pkg::KIND_FRAME_DONE, 5'd0, 8'd0, 8'd0, 8'd0);
        done_res.last_result = 1'b1;
        push0    = done_res;
        push1    = done_res;
        push_cnt = 2'd0;
        if (s_fire) begin
            if (tok_res_valid) begin
                push0 = tok_res;
                push0.last_result = !s_payload.frame_end;
                push_cnt = s_payload.frame_end ? 2'd2 : 2'd1;
            end else if (s_payload.frame_end) begin
                push_cnt = 2'd1;
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            tok_chars_reg[0]  <= 8'd0;
            tok_chars_reg[1]  <= 8'd0;
            tok_chars_reg[2]  <= 8'd0;
            tok_len_reg       <= 2'd0;
            sections_left_reg <= 4'd0;
            params_left_reg   <= 4'd0;
            section_reg       <= tctp_pkg::SEC_MODE;
            next_row_reg      <= 5'd0;
            frame_dead_reg    <= 1'b0;
        end else if (s_fire) begin
            if (s_payload.frame_end) begin
                phase_reg         <= PH_HEADER;
                tok_chars_reg[0]  <= 8'd0;
                tok_chars_reg[1]  <= 8'd0;
                tok_chars_reg[2]  <= 8'd0;
                tok_len_reg       <= 2'd0;
                sections_left_reg <= 4'd0;
                params_left_reg   <= 4'd0;
                section_reg       <= tctp_pkg::SEC_MODE;
                next_row_reg      <= 5'd0;
                frame_dead_reg    <= 1'b0;
            end else begin
                phase_reg         <= phase_next;
                sections_left_reg <= sections_left_next;
                params_left_reg   <= params_left_next;
                section_reg       <= section_next;
                next_row_reg      <= next_row_next;
                frame_dead_reg    <= frame_dead_next;
                if (is_comma) begin
                    tok_chars_reg[0] <= 8'd0;
                    tok_chars_reg[1] <= 8'd0;
                    tok_chars_reg[2] <= 8'd0;
                    tok_len_reg      <= 2'd0;
                end else begin
                    tok_chars_reg[0] <= tc[0];
                    tok_chars_reg[1] <= tc[1];
                    tok_chars_reg[2] <= tc[2];
                    tok_len_reg      <= tl;
                end
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push_cnt) - 3'(m_fire);
        end
    end

    // The queue never overflows its storage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(QDEPTH))
        else $error("result queue overflow");

    // A byte is taken only while there is room for two results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 2'd0 |-> count_reg <= 3'd2)
        else $error("result pushed without room");

    // A frame end returns the parser to its idle header state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_payload.frame_end |=>
            phase_reg == PH_HEADER && !frame_dead_reg && tok_len_reg == 2'd0)
        else $error("parser not reset after frame end");

    // Waiting for a tag implies at least one section remains.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TAG |-> sections_left_reg != 4'd0)
        else $error("tag phase with no sections left");

    // A frame end byte always yields a frame done result as its last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_payload.frame_end |-> push_cnt != 2'd0)
        else $error("frame end without frame done result");

endmodule

`default_nettype wire

// ===== dv/tctp_result_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the telecommand token parser. It predicts the results of
// every accepted command byte and compares each accepted result with the oldest
// prediction.
module tctp_result_checker (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    input  wire                  s_ready,
    input  tctp_pkg::in_item_t   s_payload,
    input  wire                  m_valid,
    input  wire                  m_ready,
    input  tctp_pkg::out_item_t  m_payload,
    output int                   mismatch_count,
    output int                   results_checked,
    output int                   frames_done,
    output int                   outstanding
);

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_SECTION_COUNT,
        ST_TAG,
        ST_PARAM_COUNT,
        ST_PARAMS,
        ST_TRAILING
    } parse_phase_t;

    // Shadow copy of the parser state.
    parse_phase_t phase;
    logic [7:0]   tok [0:2];
    int unsigned  tok_len;
    int unsigned  sections_left;
    int unsigned  params_left;
    logic [1:0]   section;
    logic [4:0]   row_ptr;
    bit           frame_dead;

    // Results predicted but not yet seen on the result channel, oldest first.
    tctp_pkg::out_item_t pending_results[$];

    // Number of results predicted for the byte under evaluation.
    int byte_result_count;

    task automatic reset_parser();
        phase         = ST_HEADER;
        tok[0]        = 8'h00;
        tok[1]        = 8'h00;
        tok[2]        = 8'h00;
        tok_len       = 0;
        sections_left = 0;
        params_left   = 0;
        section       = tctp_pkg::SEC_MODE;
        row_ptr       = 5'd0;
        frame_dead    = 1'b0;
    endtask

    // A character of the pending token as a digit, or the missing-digit value.
    function automatic logic [7:0] digit_at(int unsigned pos);
        if (pos < tok_len && pos < 3) begin
            return tok[pos] - tctp_pkg::CHAR_ZERO;
        end
        return tctp_pkg::MISSING_DIGIT;
    endfunction

    function automatic logic [7:0] column_at(int unsigned pos);
        if (pos >= tctp_pkg::COLUMNS) begin
            return 8'h00;
        end
        return digit_at(pos);
    endfunction

    function automatic int unsigned clamp_count(logic [7:0] value);
        return (value > 8'd15) ? 15 : int'(value);
    endfunction

    task automatic add_expected(logic [2:0] kind, logic [4:0] row,
                                logic [7:0] v1, logic [7:0] v2, logic [7:0] v3);
        tctp_pkg::out_item_t item;
        item.kind         = kind;
        item.row_index    = row;
        item.value_first  = v1;
        item.value_second = v2;
        item.value_third  = v3;
        item.last_result  = 1'b0;
        pending_results.push_back(item);
        byte_result_count++;
    endtask

    task automatic finish_section();
        if (sections_left > 0) begin
            sections_left--;
        end
        phase = (sections_left != 0) ? ST_TAG : ST_TRAILING;
    endtask

    // Acts on a completed token according to where the frame stands.
    task automatic close_token();
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c2;
        int unsigned depth;
        c0 = tok[0];
        c1 = tok[1];
        c2 = tok[2];
        if (frame_dead) begin
            return;
        end
        case (phase)
            ST_HEADER: begin
                if (tok_len == 3 && c0 == tctp_pkg::CHAR_T && c1 == tctp_pkg::CHAR_U
                    && c2 == tctp_pkg::CHAR_B) begin
                    phase = ST_SECTION_COUNT;
                end else begin
                    add_expected(tctp_pkg::KIND_BAD_HEADER, 5'd0, 8'h00, 8'h00, 8'h00);
                    frame_dead = 1'b1;
                end
            end
            ST_SECTION_COUNT: begin
                sections_left = clamp_count(digit_at(0));
                phase = (sections_left != 0) ? ST_TAG : ST_TRAILING;
            end
            ST_TAG: begin
                if (tok_len >= 2 && c0 == tctp_pkg::CHAR_M && c1 == tctp_pkg::CHAR_D) begin
                    section = tctp_pkg::SEC_MODE;
                    phase   = ST_PARAM_COUNT;
                end else if (tok_len >= 2 && c0 == tctp_pkg::CHAR_H
                             && c1 == tctp_pkg::CHAR_T) begin
                    section = tctp_pkg::SEC_HEATER;
                    phase   = ST_PARAM_COUNT;
                end else if (tok_len >= 2 && c0 == tctp_pkg::CHAR_S
                             && c1 == tctp_pkg::CHAR_C) begin
                    section = tctp_pkg::SEC_SCAN;
                    phase   = ST_PARAM_COUNT;
                end else if (tok_len >= 2 && c0 == tctp_pkg::CHAR_S
                             && c1 == tctp_pkg::CHAR_S) begin
                    section = tctp_pkg::SEC_SAMPLING;
                    phase   = ST_PARAM_COUNT;
                end else begin
                    add_expected(tctp_pkg::KIND_UNKNOWN, 5'd0, 8'h00, 8'h00, 8'h00);
                    frame_dead = 1'b1;
                end
            end
            ST_PARAM_COUNT: begin
                params_left = clamp_count(digit_at(0));
                row_ptr     = 5'd0;
                if (params_left == 0) begin
                    finish_section();
                end else begin
                    phase = ST_PARAMS;
                end
            end
            ST_PARAMS: begin
                // Mode and sampling take only their first parameter.
                if (section == tctp_pkg::SEC_MODE) begin
                    if (row_ptr == 5'd0) begin
                        add_expected(tctp_pkg::KIND_MODE, 5'd0, digit_at(0),
                                     8'h00, 8'h00);
                    end
                end else if (section == tctp_pkg::SEC_SAMPLING) begin
                    if (row_ptr == 5'd0) begin
                        add_expected(tctp_pkg::KIND_SAMPLING, 5'd0,
                                     (tok_len != 0) ? c0 : 8'h00, 8'h00, 8'h00);
                    end
                end else begin
                    depth = (section == tctp_pkg::SEC_HEATER) ? tctp_pkg::HEATER_ROWS
                                                              : tctp_pkg::SCAN_ROWS;
                    if (row_ptr >= depth) begin
                        add_expected(tctp_pkg::KIND_ROW_RANGE, row_ptr,
                                     8'h00, 8'h00, 8'h00);
                    end else begin
                        add_expected((section == tctp_pkg::SEC_HEATER)
                                         ? tctp_pkg::KIND_HEATER : tctp_pkg::KIND_SCAN,
                                     row_ptr, column_at(0), column_at(1), column_at(2));
                    end
                end
                if (row_ptr < 5'd31) begin
                    row_ptr++;
                end
                if (params_left > 0) begin
                    params_left--;
                end
                if (params_left == 0) begin
                    finish_section();
                end
            end
            default: begin
                // Tokens after the last section are ignored.
            end
        endcase
    endtask

    // Works out the results of one accepted command byte.
    task automatic predict_command_byte(tctp_pkg::in_item_t item);
        tctp_pkg::out_item_t last_item;
        byte_result_count = 0;
        if (item.in_byte != tctp_pkg::CHAR_COMMA && tok_len < 3) begin
            tok[tok_len] = item.in_byte;
            tok_len++;
        end
        if (item.in_byte == tctp_pkg::CHAR_COMMA || item.frame_end) begin
            close_token();
            tok[0]  = 8'h00;
            tok[1]  = 8'h00;
            tok[2]  = 8'h00;
            tok_len = 0;
        end
        if (item.frame_end) begin
            add_expected(tctp_pkg::KIND_FRAME_DONE, 5'd0, 8'h00, 8'h00, 8'h00);
            reset_parser();
        end
        if (byte_result_count > 0) begin
            last_item = pending_results.pop_back();
            last_item.last_result = 1'b1;
            pending_results.push_back(last_item);
        end
    endtask

    task automatic check_result(tctp_pkg::out_item_t got);
        tctp_pkg::out_item_t want;
        results_checked++;
        if (got.kind == tctp_pkg::KIND_FRAME_DONE) begin
            frames_done++;
        end
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: result with none pending: kind %0d row %0d",
                         $realtime, got.kind, got.row_index);
                $display("%0t:   values %0d %0d %0d last %0d", $realtime,
                         got.value_first, got.value_second, got.value_third,
                         got.last_result);
            end
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.row_index !== want.row_index ||
            got.value_first !== want.value_first ||
            got.value_second !== want.value_second ||
            got.value_third !== want.value_third ||
            got.last_result !== want.last_result) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: result mismatch, expected kind %0d row %0d %0d %0d %0d last %0d",
                         $realtime, want.kind, want.row_index, want.value_first,
                         want.value_second, want.value_third, want.last_result);
                $display("%0t:                    got kind %0d row %0d %0d %0d %0d last %0d",
                         $realtime, got.kind, got.row_index, got.value_first,
                         got.value_second, got.value_third, got.last_result);
            end
        end
    endtask

    // Predict on accepted requests, compare on accepted results.
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_parser();
            pending_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_command_byte(s_payload);
            end
            if (m_valid && m_ready) begin
                check_result(m_payload);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ===== dv/tb_telecommand_token_parser_core.sv =====
`timescale 1ns / 1ps

module tb_telecommand_token_parser_core;

    localparam int BYTE_TARGET    = 1150;
    localparam int NO_IDLE_FROM   = 950;
    localparam int HOLD_OFF_AT    = 300;
    localparam int HOLD_OFF_LEN   = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    tctp_pkg::in_item_t  s_payload;
    logic                m_valid;
    logic                m_ready;
    tctp_pkg::out_item_t m_payload;

    int mismatch_count;
    int results_checked;
    int frames_done;
    int outstanding;

    int  bytes_sent;
    int  frames_sent;
    int  idle_cycles;
    int  hold_off_left;
    int  stall_left;
    bit  sender_idles;
    bit  receiver_idles;
    bit  hold_off_req;
    bit  hold_off_taken;

    // Bytes of the frame being assembled.
    logic [7:0] frame_q[$];

    telecommand_token_parser_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    tctp_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload),
        .mismatch_count  (mismatch_count),
        .results_checked (results_checked),
        .frames_done     (frames_done),
        .outstanding     (outstanding)
    );

    // 2 ns clock.
    initial begin
        aclk = 1'b0;
    end

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        m_ready        = 1'b0;
        stall_left     = 0;
        hold_off_left  = 0;
        hold_off_taken = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_taken) begin
                hold_off_left  = HOLD_OFF_LEN;
                hold_off_taken = 1'b1;
            end
            if (hold_off_left > 0) begin
                m_ready <= 1'b0;
                hold_off_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one byte, with an optional idle burst first, and waits for acceptance.
    task automatic send_byte(logic [7:0] value, logic last);
        int gap;
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_payload.in_byte   <= value;
        s_payload.frame_end <= last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(string text, bit end_on_last);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i], end_on_last && (i == text.len() - 1));
        end
    endtask

    function automatic void add_text(string text);
        for (int i = 0; i < text.len(); i++) begin
            frame_q.push_back(text[i]);
        end
    endfunction

    function automatic int unsigned count_of(logic [7:0] c);
        logic [7:0] value;
        value = c - tctp_pkg::CHAR_ZERO;
        return (value > 8'd15) ? 15 : int'(value);
    endfunction

    function automatic logic [7:0] random_digit(int unsigned top_digit);
        return tctp_pkg::CHAR_ZERO + 8'($urandom_range(0, top_digit));
    endfunction

    // A parameter token of zero to four characters, mostly digits.
    function automatic void add_param_token();
        int unsigned len;
        logic [7:0]  c;
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        repeat (len) begin
            if ($urandom_range(0, 7) == 0) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                c = random_digit(9);
            end
            frame_q.push_back(c);
        end
        frame_q.push_back(tctp_pkg::CHAR_COMMA);
    endfunction

    // Assembles one frame: mostly well formed with random content, some broken.
    function automatic void build_command_frame();
        int unsigned n_sections;
        int unsigned n_params;
        int unsigned len;
        int unsigned cut;
        logic [7:0]  c;
        frame_q.delete();
        if ($urandom_range(0, 19) == 0) begin
            // Line noise.
            len = $urandom_range(1, 12);
            repeat (len) begin
                c = 8'($urandom_range(0, 255));
                frame_q.push_back(c);
            end
            return;
        end
        case ($urandom_range(0, 15))
            0: add_text("tu");
            1: add_text("tuba");
            2: add_text("tib");
            3: begin
                add_text("tu");
                c = 8'($urandom_range(0, 255));
                frame_q.push_back(c);
            end
            default: add_text("tub");
        endcase
        frame_q.push_back(tctp_pkg::CHAR_COMMA);
        if ($urandom_range(0, 19) == 0) begin
            c = 8'($urandom_range(0, 255));
        end else begin
            c = random_digit(4);
        end
        n_sections = count_of(c);
        frame_q.push_back(c);
        frame_q.push_back(tctp_pkg::CHAR_COMMA);
        repeat (n_sections) begin
            case ($urandom_range(0, 19))
                0: begin
                    c = 8'($urandom_range(0, 255));
                    frame_q.push_back(c);
                    c = 8'($urandom_range(0, 255));
                    frame_q.push_back(c);
                end
                1: add_text("m");
                2: add_text("htx");
                3, 4, 5, 6: add_text("md");
                7, 8, 9, 10: add_text("ht");
                11, 12, 13, 14: add_text("sc");
                default: add_text("ss");
            endcase
            frame_q.push_back(tctp_pkg::CHAR_COMMA);
            if ($urandom_range(0, 9) == 0) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                c = random_digit(8);
            end
            n_params = count_of(c);
            frame_q.push_back(c);
            frame_q.push_back(tctp_pkg::CHAR_COMMA);
            repeat (n_params) add_param_token();
        end
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) add_param_token();
        end
        // The frame now ends in a comma; choose how it is closed.
        case ($urandom_range(0, 5))
            0: begin
                // Frame end carried by the final comma.
            end
            1: begin
                cut = $urandom_range(1, frame_q.size());
                while (frame_q.size() > cut) begin
                    void'(frame_q.pop_back());
                end
            end
            default: void'(frame_q.pop_back());
        endcase
    endfunction

    // Stimulus and verdict.
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_payload      = '0;
        bytes_sent     = 0;
        frames_sent    = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_off_req   = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Bad header that is wrong in its last character.
        send_text("tuX", 1'b1);
        // Bad header made of the byte extremes, closed by a comma with frame end.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(tctp_pkg::CHAR_COMMA, 1'b1);
        // Saturated section count, extra mode parameter, empty sampling token,
        // long and short heater tokens, a heater row past the table, unknown tag.
        send_text("tub,~,md,2,5,7,ss,1,,ht,7,1234,,9,0,0,0,0,xx,1", 1'b1);
        // Scan row, then trailing tokens, frame end on a comma.
        send_text("tub,1,sc,1,98,md,4,", 1'b1);
        frames_sent += 4;

        while (bytes_sent < BYTE_TARGET) begin
            if (bytes_sent >= NO_IDLE_FROM) begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end else begin
                sender_idles   = ($urandom_range(0, 3) != 0);
                receiver_idles = ($urandom_range(0, 3) != 0);
            end
            if (!hold_off_req && bytes_sent >= HOLD_OFF_AT) begin
                hold_off_req = 1'b1;
            end
            build_command_frame();
            foreach (frame_q[i]) begin
                send_byte(frame_q[i], i == frame_q.size() - 1);
            end
            frames_sent++;
        end
        s_valid <= 1'b0;

        // Drain the remaining results, then allow a little slack for strays.
        while (outstanding != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d command bytes in %0d frames, with random idling", bytes_sent,
                 frames_sent);
        $display("and one long result hold-off; checked %0d results (%0d frame ends).",
                 results_checked, frames_done);
        $display("%0d mismatches, %0d results left pending.", mismatch_count,
                 outstanding);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tctp_pkg.sv
design/telecommand_token_parser_core.sv
dv/tctp_result_checker.sv
dv/tb_telecommand_token_parser_core.sv
